FILE: rtl/bitplane_byterun1_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ByteRun1 bitplane decoder
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BITPLANE_BYTERUN1_DECODER_ASSERT_SVH
`define BITPLANE_BYTERUN1_DECODER_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted
`define BBR1_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bbr1 same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted
`define BBR1_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bbr1 next-cycle check failed");

`endif

FILE: rtl/bbr1_pkg.sv
// ----------------------------------------------------------------------------
// bbr1_pkg
// Types and constants shared by the ByteRun1 bitplane decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bbr1_pkg;

  localparam int unsigned ROW_BYTES_W = 14;
  localparam int unsigned ROWS_W      = 16;
  localparam int unsigned CURSOR_W    = 13;
  localparam int unsigned PLANE_W     = 5;
  localparam int unsigned CFG_DATA_W  = 16;

  // Register indexes
  localparam logic CFG_ROW_BYTES  = 1'b0;
  localparam logic CFG_IMAGE_ROWS = 1'b1;

  // Reset values of the registers
  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST  = 14'd2;
  localparam logic [ROWS_W-1:0]      IMAGE_ROWS_RST = 16'd1;

  // Header byte that does nothing
  localparam logic [7:0] NOOP_HEADER = 8'h80;

  // 24 planes per pixel row: 3 components times 8 bits
  localparam logic [PLANE_W-1:0] LAST_PLANE = 5'd23;

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_LITERAL,
    MODE_REPEAT
  } mode_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PLANE_W-1:0]  plane_index;
    logic [ROWS_W-1:0]   row_index;
    logic [CURSOR_W-1:0] byte_position;
    logic [7:0]          run_value;
    logic [7:0]          run_count;
    logic                plane_row_end;
    logic                image_end;
    logic                overrun;
  } out_item_t;

  // Run command from the front end to the back end
  typedef struct packed {
    logic       clear;        // reset cursors and discard state first
    logic       emit;         // carries a literal or repeat value byte
    logic       packet_left;  // more literal bytes follow in this packet
    logic [7:0] value;
    logic [7:0] want;         // requested byte count, 1..128
  } cmd_t;

  typedef struct packed {
    logic [ROW_BYTES_W-1:0] row_bytes;
    logic [ROWS_W-1:0]      image_rows;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/bbr1_front.sv
// ----------------------------------------------------------------------------
// bbr1_front
// Header parser: accepts stream bytes, tracks packet mode and count, and
// turns value bytes and frame starts into run commands.
// ----------------------------------------------------------------------------
`default_nettype none

module bbr1_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire bbr1_pkg::in_item_t in_item_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output bbr1_pkg::cmd_t         cmd_o
);

  bbr1_pkg::mode_e mode_q, mode_d, mode_eff;
  logic [7:0]      pending_q, pending_d, pending_eff, pending_dec;
  logic            accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // frame start forces header mode before the byte is looked at
  assign mode_eff    = in_item_i.frame_start ? bbr1_pkg::MODE_HEADER : mode_q;
  assign pending_eff = in_item_i.frame_start ? 8'd0 : pending_q;
  assign pending_dec = pending_eff - 8'd1;

  // next state
  always_comb begin
    mode_d    = mode_q;
    pending_d = pending_q;
    if (accept) begin
      unique case (mode_eff)
        bbr1_pkg::MODE_HEADER: begin
          if (in_item_i.data_byte < bbr1_pkg::NOOP_HEADER) begin
            pending_d = in_item_i.data_byte + 8'd1;
            mode_d    = bbr1_pkg::MODE_LITERAL;
          end else if (in_item_i.data_byte > bbr1_pkg::NOOP_HEADER) begin
            // 257 - n modulo 256
            pending_d = 8'd1 - in_item_i.data_byte;
            mode_d    = bbr1_pkg::MODE_REPEAT;
          end else begin
            pending_d = pending_eff;
            mode_d    = bbr1_pkg::MODE_HEADER;
          end
        end
        bbr1_pkg::MODE_LITERAL: begin
          pending_d = pending_dec;
          mode_d    = (pending_dec == 8'd0) ? bbr1_pkg::MODE_HEADER
                                            : bbr1_pkg::MODE_LITERAL;
        end
        bbr1_pkg::MODE_REPEAT: begin
          pending_d = 8'd0;
          mode_d    = bbr1_pkg::MODE_HEADER;
        end
        default: begin
          pending_d = 8'd0;
          mode_d    = bbr1_pkg::MODE_HEADER;
        end
      endcase
    end
  end

  // command build
  always_comb begin
    cmd_o.clear       = in_item_i.frame_start;
    cmd_o.value       = in_item_i.data_byte;
    cmd_o.emit        = 1'b0;
    cmd_o.packet_left = 1'b0;
    cmd_o.want        = 8'd1;
    unique case (mode_eff)
      bbr1_pkg::MODE_LITERAL: begin
        cmd_o.emit        = 1'b1;
        cmd_o.packet_left = (pending_dec != 8'd0);
      end
      bbr1_pkg::MODE_REPEAT: begin
        cmd_o.emit = 1'b1;
        cmd_o.want = pending_eff;
      end
      default: begin
        cmd_o.emit = 1'b0;
      end
    endcase
    // headers only travel when they carry a frame start
    push_o = accept && (cmd_o.emit || in_item_i.frame_start);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= bbr1_pkg::MODE_HEADER;
      pending_q <= 8'd0;
    end else begin
      mode_q    <= mode_d;
      pending_q <= pending_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bbr1_cmd_fifo.sv
// ----------------------------------------------------------------------------
// bbr1_cmd_fifo
// Two-entry command queue between the header parser and the run unit.
// ----------------------------------------------------------------------------
`default_nettype none

module bbr1_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bbr1_pkg::cmd_t cmd_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output bbr1_pkg::cmd_t      cmd_o
);

  bbr1_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q, count_d;
  logic           do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) count_d = count_q + 2'd1;
    else if (!do_push && do_pop) count_d = count_q - 2'd1;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= cmd_i;
  end

endmodule

`default_nettype wire

FILE: rtl/bbr1_back.sv
// ----------------------------------------------------------------------------
// bbr1_back
// Run unit: places each run command at the plane/row cursor, clips at the
// row end, drops the tail of an overrun literal packet, and holds the
// result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbr1_back #(
  parameter int unsigned MAX_ROW_BYTES = 8192
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire bbr1_pkg::cfg_t   cfg_i,
  input  wire logic             q_valid_i,
  input  wire bbr1_pkg::cmd_t   cmd_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output bbr1_pkg::out_item_t   out_item_o
);

  localparam int unsigned RBW = bbr1_pkg::ROW_BYTES_W;
  localparam int unsigned CW  = bbr1_pkg::CURSOR_W;
  localparam int unsigned RW  = bbr1_pkg::ROWS_W;
  localparam int unsigned PW  = bbr1_pkg::PLANE_W;
  localparam logic [RBW-1:0] MAX_RB = RBW'(MAX_ROW_BYTES);

  logic [CW-1:0]  byte_cur_q, byte_cur_d, byte_cur_b;
  logic [PW-1:0]  plane_cur_q, plane_cur_d, plane_cur_b;
  logic [RW-1:0]  row_cur_q, row_cur_d, row_cur_b;
  logic           discard_q, discard_d, discard_b;
  logic           out_valid_q, out_valid_d;
  bbr1_pkg::out_item_t out_q, res;

  logic [RBW-1:0] eff, left, want_w, count_w, cur_w;
  logic [RW-1:0]  rows_m1;
  logic           clipped, row_end, img_end, do_run;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign pop_o       = q_valid_i && (!out_valid_q || !out_stall_i);

  // cursors seen by this command, after an optional frame clear
  assign byte_cur_b  = cmd_i.clear ? '0 : byte_cur_q;
  assign plane_cur_b = cmd_i.clear ? '0 : plane_cur_q;
  assign row_cur_b   = cmd_i.clear ? '0 : row_cur_q;
  assign discard_b   = cmd_i.clear ? 1'b0 : discard_q;
  assign do_run      = pop_o && cmd_i.emit && !discard_b;

  // effective row length and bytes left in the row
  always_comb begin
    if (cfg_i.row_bytes == '0)         eff = RBW'(1);
    else if (cfg_i.row_bytes > MAX_RB) eff = MAX_RB;
    else                               eff = cfg_i.row_bytes;
    rows_m1 = (cfg_i.image_rows == '0) ? '0 : cfg_i.image_rows - RW'(1);
    cur_w   = {1'b0, byte_cur_b};
    left    = (cur_w < eff) ? (eff - cur_w) : RBW'(1);
    want_w  = {{(RBW-8){1'b0}}, cmd_i.want};
    clipped = (want_w > left);
    count_w = clipped ? left : want_w;
    row_end = (count_w == left);
    img_end = row_end && (plane_cur_b >= bbr1_pkg::LAST_PLANE) && (row_cur_b >= rows_m1);
  end

  // result fields
  always_comb begin
    res.plane_index   = plane_cur_b;
    res.row_index     = row_cur_b;
    res.byte_position = byte_cur_b;
    res.run_value     = cmd_i.value;
    res.run_count     = count_w[7:0];
    res.plane_row_end = row_end;
    res.image_end     = img_end;
    res.overrun       = clipped || (row_end && cmd_i.packet_left);
  end

  // cursor and discard update
  always_comb begin
    byte_cur_d  = byte_cur_q;
    plane_cur_d = plane_cur_q;
    row_cur_d   = row_cur_q;
    discard_d   = discard_q;
    if (pop_o) begin
      byte_cur_d  = byte_cur_b;
      plane_cur_d = plane_cur_b;
      row_cur_d   = row_cur_b;
      discard_d   = discard_b;
      if (cmd_i.emit && discard_b) begin
        // tail of a clipped literal packet: consumed silently
        discard_d = cmd_i.packet_left;
      end else if (do_run) begin
        discard_d = row_end && cmd_i.packet_left;
        if (row_end) begin
          byte_cur_d = '0;
          if (img_end) begin
            plane_cur_d = '0;
            row_cur_d   = '0;
          end else if (plane_cur_b >= bbr1_pkg::LAST_PLANE) begin
            plane_cur_d = '0;
            row_cur_d   = row_cur_b + RW'(1);
          end else begin
            plane_cur_d = plane_cur_b + PW'(1);
          end
        end else begin
          byte_cur_d = byte_cur_b + count_w[CW-1:0];
        end
      end
    end
  end

  // output register handshake
  always_comb begin
    if (do_run)            out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else                   out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cur_q  <= '0;
      plane_cur_q <= '0;
      row_cur_q   <= '0;
      discard_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      byte_cur_q  <= byte_cur_d;
      plane_cur_q <= plane_cur_d;
      row_cur_q   <= row_cur_d;
      discard_q   <= discard_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_run) out_q <= res;
  end

endmodule

`default_nettype wire

FILE: rtl/bitplane_byterun1_decoder.sv
// Path: a value byte accepted by the parser is written into the command
//   queue; the run unit then registers its result, raising out_valid_o.
// Throughput: one byte per cycle; the run unit updates its cursors as it
//   takes each command. An output stall holds the run unit, and the input
//   stalls once the two-entry queue has filled.
// Reset: rst_ni (async, low) clears mode, cursors and queue; row_bytes
//   returns to 2 and image_rows to 1. No clearing pass is needed.
// ----------------------------------------------------------------------------
// bitplane_byterun1_decoder
// ByteRun1 stream decoder that emits byte runs for 24-plane bitmap rows.
// ----------------------------------------------------------------------------
`default_nettype none

module bitplane_byterun1_decoder #(
  parameter int unsigned MAX_ROW_BYTES = 8192
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic                                 cfg_index_i,
  input  wire logic [bbr1_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire bbr1_pkg::in_item_t                   in_item_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output bbr1_pkg::out_item_t                       out_item_o
);

  bbr1_pkg::cfg_t cfg_q;
  bbr1_pkg::cmd_t push_cmd, pop_cmd;
  logic           push, pop, q_full, q_valid;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_bytes  <= bbr1_pkg::ROW_BYTES_RST;
      cfg_q.image_rows <= bbr1_pkg::IMAGE_ROWS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bbr1_pkg::CFG_ROW_BYTES:  cfg_q.row_bytes  <= cfg_data_i[bbr1_pkg::ROW_BYTES_W-1:0];
        bbr1_pkg::CFG_IMAGE_ROWS: cfg_q.image_rows <= cfg_data_i[bbr1_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  bbr1_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  bbr1_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .cmd_o   (pop_cmd)
  );

  bbr1_back #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

FILE: rtl/bbr1_checker.sv
// ----------------------------------------------------------------------------
// bbr1_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitplane_byterun1_decoder_assert.svh"

module bbr1_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire bbr1_pkg::out_item_t out_item_o
);

  // a stalled result stays offered
  `BBR1_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // run counts lie in 1..128
  `BBR1_ASSERT_NOW(a_count_range, clk_i, rst_ni, out_valid_o, (out_item_o.run_count != 8'd0) && (out_item_o.run_count <= 8'd128))

  // a clipped run always finishes its plane row
  `BBR1_ASSERT_NOW(a_overrun_ends_row, clk_i, rst_ni, out_valid_o && out_item_o.overrun, out_item_o.plane_row_end)

  // image end only on the last plane at a row end
  `BBR1_ASSERT_NOW(a_image_end_plane, clk_i, rst_ni, out_valid_o && out_item_o.image_end, out_item_o.plane_row_end && (out_item_o.plane_index == bbr1_pkg::LAST_PLANE))

endmodule

bind bitplane_byterun1_decoder bbr1_checker u_bbr1_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
